[sv/sgs_pkg.sv]
// Shared types, constants and arithmetic helpers for the spline grid gradient scatter.
package sgs_pkg;

    localparam int MAX_DIMS     = 3;
    localparam int MAX_ORDER    = 3;
    localparam int MAX_CHANNELS = 4;
    localparam int POS_W        = 18;
    localparam int GRAD_W       = 16;
    localparam int IDX_W        = 16;
    localparam int VAL_W        = 24;
    localparam int KERN_W       = 30;
    localparam int SETUP_W      = 20;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [2:0] REG_NUM_DIMS     = 3'd0;
    localparam logic [2:0] REG_NUM_CHANNELS = 3'd1;
    localparam logic [2:0] REG_DIM0_SETUP   = 3'd2;
    localparam logic [2:0] REG_DIM1_SETUP   = 3'd3;
    localparam logic [2:0] REG_DIM2_SETUP   = 3'd4;

    localparam logic [SETUP_W-1:0] SETUP_RESET = 20'h30004;
    localparam logic [28:0]        E_INV30     = 29'd395007542;
    localparam logic signed [47:0] KLIM        = 48'sd68719476736;
    localparam logic signed [63:0] VMAX        = 64'sd8388607;
    localparam logic signed [63:0] VMIN        = -64'sd8388608;

    typedef struct packed {
        logic [1:0]                       nd;
        logic [2:0]                       nc;
        logic [MAX_DIMS-1:0][SETUP_W-1:0] setup;
    } t_cfg;

    typedef struct packed {
        logic [MAX_DIMS-1:0][IDX_W-1:0]      base;
        logic [MAX_DIMS-1:0][15:0]           frac;
        logic [MAX_DIMS-1:0][1:0]            order;
        logic [MAX_DIMS-1:0][1:0]            deriv;
        logic [1:0]                          nd;
        logic [2:0]                          nc;
        logic [MAX_CHANNELS-1:0][GRAD_W-1:0] grad;
        logic                                oor;
    } t_point;

    typedef struct packed {
        logic signed [17:0] x;
        logic [1:0]         order;
        logic [1:0]         deriv;
    } t_kn_req;

    typedef struct packed {
        logic [MAX_DIMS-1:0][IDX_W-1:0]      idx;
        logic [MAX_CHANNELS-1:0][GRAD_W-1:0] grad;
        logic [2:0]                          nc;
        logic                                oor;
        logic                                last;
    } t_emit;

    typedef enum logic [3:0] {
        KN_IDLE, KN_SQ, KN_HORN, KN_EXPI, KN_NORM, KN_PROD, KN_SUM, KN_SCALE, KN_OUT
    } t_kn_state;

    typedef enum logic [1:0] {
        BK_IDLE, BK_KERN, BK_WAIT, BK_EMIT
    } t_bk_state;

    // floor(2^30 / k!)
    function automatic logic [30:0] exp_coef(input logic [3:0] k);
        logic [30:0] c;
        case (k)
            4'd0:    c = 31'd1073741824;
            4'd1:    c = 31'd1073741824;
            4'd2:    c = 31'd536870912;
            4'd3:    c = 31'd178956970;
            4'd4:    c = 31'd44739242;
            4'd5:    c = 31'd8947848;
            4'd6:    c = 31'd1491308;
            4'd7:    c = 31'd213044;
            4'd8:    c = 31'd26630;
            4'd9:    c = 31'd2958;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

    // 1/sqrt(2*pi*(n+1)/12), Q.30
    function automatic logic [30:0] norm30(input logic [1:0] n);
        logic [30:0] c;
        case (n)
            2'd1:    c = 31'd1049265905;
            2'd2:    c = 31'd856722023;
            2'd3:    c = 31'd741943036;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

    // arithmetic right shift, rounding half away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? $signed(64'd0 - mag) : $signed(mag);
    endfunction

endpackage

[sv/sgs_if.sv]
// Point input and neighbor output channel interfaces.
interface sgs_in_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_0;
    logic signed [17:0] pos_1;
    logic signed [17:0] pos_2;
    logic signed [15:0] grad_0;
    logic signed [15:0] grad_1;
    logic signed [15:0] grad_2;
    logic signed [15:0] grad_3;

    modport source (output valid, pos_0, pos_1, pos_2, grad_0, grad_1, grad_2, grad_3,
                    input ready);
    modport sink (input valid, pos_0, pos_1, pos_2, grad_0, grad_1, grad_2, grad_3,
                  output ready);
endinterface

interface sgs_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        index_0;
    logic [15:0]        index_1;
    logic [15:0]        index_2;
    logic signed [23:0] value_0;
    logic signed [23:0] value_1;
    logic signed [23:0] value_2;
    logic signed [23:0] value_3;
    logic               out_of_range;
    logic               last;

    modport source (output valid, index_0, index_1, index_2, value_0, value_1, value_2,
                    value_3, out_of_range, last, input ready);
    modport sink (input valid, index_0, index_1, index_2, value_0, value_1, value_2,
                  value_3, out_of_range, last, output ready);
endinterface

[sv/sgs_front.sv]
// Front end: accepts a point, finds base index, fraction and range per dimension.
module sgs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sgs_in_if.sink          i_pt,
    input  sgs_pkg::t_cfg   i_cfg,
    output sgs_pkg::t_point o_pt,
    output logic            o_valid,
    input  logic            i_ready
);
    import sgs_pkg::*;

    logic   r_v;
    t_point r_pt;
    t_point n_pt;
    logic   w_acc;

    assign i_pt.ready = !r_v || i_ready;
    assign w_acc      = i_pt.valid && i_pt.ready;
    assign o_valid    = r_v;
    assign o_pt       = r_pt;

    always_comb begin
        logic [MAX_DIMS-1:0][POS_W-1:0] pos;
        logic [15:0] size;
        logic [15:0] span;
        logic [31:0] prod;
        logic [1:0]  nd;
        n_pt = '0;
        pos[0] = i_pt.pos_0;
        pos[1] = i_pt.pos_1;
        pos[2] = i_pt.pos_2;
        nd = (i_cfg.nd == 2'd0) ? 2'd1 : i_cfg.nd;
        n_pt.nd = nd;
        if (i_cfg.nc == 3'd0) begin
            n_pt.nc = 3'd1;
        end else if (i_cfg.nc > 3'(MAX_CHANNELS)) begin
            n_pt.nc = 3'(MAX_CHANNELS);
        end else begin
            n_pt.nc = i_cfg.nc;
        end
        n_pt.grad[0] = i_pt.grad_0;
        n_pt.grad[1] = i_pt.grad_1;
        n_pt.grad[2] = i_pt.grad_2;
        n_pt.grad[3] = i_pt.grad_3;
        for (int d = 0; d < MAX_DIMS; d++) begin
            size = i_cfg.setup[d][15:0];
            span = (size >= 16'd3) ? size - 16'd3 : 16'd0;
            prod = pos[d][15:0] * span;
            n_pt.order[d] = (i_cfg.setup[d][17:16] == 2'd0) ? 2'd1 : i_cfg.setup[d][17:16];
            n_pt.deriv[d] = i_cfg.setup[d][19:18];
            if (d < int'(nd)) begin
                if (pos[d][17:16] != 2'b00) begin
                    n_pt.oor = 1'b1;
                end else begin
                    n_pt.base[d] = prod[31:16];
                    n_pt.frac[d] = prod[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_acc) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pt <= n_pt;
        end
    end

endmodule

[sv/sgs_queue.sv]
// Short point queue between front and back end.
module sgs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgs_pkg::t_point i_pt,
    input  logic            i_valid,
    output logic            o_ready,
    output sgs_pkg::t_point o_pt,
    output logic            o_valid,
    input  logic            i_ready
);
    import sgs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_point           r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = r_cnt != (AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_pt    = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_pt;
        end
    end

endmodule

[sv/sgs_kernel.sv]
// Iterative Gaussian kernel and Hermite derivative unit, Q.22 result.
module sgs_kernel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  sgs_pkg::t_kn_req          i_req,
    output logic                      o_done,
    output logic signed [sgs_pkg::KERN_W-1:0] o_k
);
    import sgs_pkg::*;

    t_kn_state          r_st;
    t_kn_state          n_st;
    logic signed [17:0] r_x;
    logic [1:0]         r_n;
    logic [1:0]         r_d;
    logic [34:0]        r_x2;
    logic [30:0]        r_r;
    logic [3:0]         r_cnt;
    logic signed [37:0] r_p1;
    logic signed [37:0] r_p2;
    logic [1:0]         r_kk;
    logic signed [55:0] r_prod;
    logic signed [41:0] r_t;

    logic [35:0]        w_e3;
    logic [35:0]        w_e;
    logic [3:0]         w_ip;
    logic [29:0]        w_f;
    logic [60:0]        w_hp;
    logic [59:0]        w_ep;
    logic [61:0]        w_np;
    logic signed [63:0] w_rs;
    logic signed [41:0] w_pk;
    logic signed [47:0] w_t48;
    logic signed [47:0] w_m;
    logic signed [47:0] w_nw;
    logic signed [63:0] w_kr;

    assign w_e3 = {1'b0, r_x2} + {r_x2, 1'b0};
    always_comb begin
        case (r_n)
            2'd1:    w_e = w_e3;
            2'd2:    w_e = {r_x2, 1'b0};
            default: w_e = w_e3 >> 1;
        endcase
    end
    assign w_ip = w_e[35:32];
    assign w_f  = w_e[31:2];
    assign w_hp = w_f * r_r + 61'd536870912;
    assign w_ep = r_r * E_INV30 + 60'd536870912;
    assign w_np = norm30(r_n) * r_r + 62'd536870912;
    assign w_rs = rnd_sh({{8{r_prod[55]}}, r_prod}, 16);
    always_comb begin
        case (r_kk)
            2'd2:    w_pk = 42'(r_p2);
            2'd3:    w_pk = 42'(r_p2) <<< 1;
            default: w_pk = '0;
        endcase
    end
    assign w_t48 = 48'(r_t);
    always_comb begin
        case (r_n)
            2'd1:    w_m = (w_t48 <<< 2) + (w_t48 <<< 1);
            2'd2:    w_m = w_t48 <<< 2;
            default: w_m = (w_t48 <<< 1) + w_t48;
        endcase
    end
    always_comb begin
        w_nw = -w_m;
        if (w_nw > KLIM) begin
            w_nw = KLIM;
        end else if (w_nw < -KLIM) begin
            w_nw = -KLIM;
        end
    end
    assign w_kr = rnd_sh(64'(r_p1), 8);

    always_comb begin
        n_st = r_st;
        case (r_st)
            KN_IDLE:  if (i_start) n_st = KN_SQ;
            KN_SQ:    n_st = KN_HORN;
            KN_HORN:  if (r_cnt == 4'd0) n_st = KN_EXPI;
            KN_EXPI:  if (r_cnt == w_ip) n_st = KN_NORM;
            KN_NORM:  n_st = (r_d == 2'd0) ? KN_OUT : KN_PROD;
            KN_PROD:  n_st = KN_SUM;
            KN_SUM:   n_st = KN_SCALE;
            KN_SCALE: n_st = (r_kk == r_d) ? KN_OUT : KN_PROD;
            KN_OUT:   n_st = KN_IDLE;
            default:  n_st = KN_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_st == KN_OUT);
        o_k    = w_kr[KERN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= KN_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            KN_IDLE: begin
                r_x <= i_req.x;
                r_n <= i_req.order;
                r_d <= i_req.deriv;
            end
            KN_SQ: begin
                r_x2  <= 35'(r_x * r_x);
                r_r   <= exp_coef(4'd9);
                r_cnt <= 4'd8;
            end
            KN_HORN: begin
                r_r   <= exp_coef(r_cnt) - w_hp[60:30];
                r_cnt <= (r_cnt == 4'd0) ? 4'd0 : r_cnt - 4'd1;
            end
            KN_EXPI: begin
                if (r_cnt != w_ip) begin
                    r_r   <= {1'b0, w_ep[59:30]};
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            KN_NORM: begin
                r_p1 <= {6'd0, w_np[61:30]};
                r_p2 <= '0;
                r_kk <= 2'd1;
            end
            KN_PROD: begin
                r_prod <= r_x * r_p1;
            end
            KN_SUM: begin
                r_t <= w_rs[41:0] + w_pk;
            end
            KN_SCALE: begin
                r_p2 <= r_p1;
                r_p1 <= w_nw[37:0];
                r_kk <= r_kk + 2'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/sgs_back.sv]
// Back end: kernel table fill, neighbor walk and weight/value pipeline.
module sgs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sgs_pkg::t_point           i_pt,
    input  logic                      i_valid,
    output logic                      o_ready,
    output logic                      o_kn_start,
    output sgs_pkg::t_kn_req          o_kn_req,
    input  logic                      i_kn_done,
    input  logic signed [sgs_pkg::KERN_W-1:0] i_kn_k,
    sgs_out_if.source                 o_nb
);
    import sgs_pkg::*;

    t_bk_state r_st;
    t_bk_state n_st;
    t_point    r_pt;
    logic [1:0] r_kd;
    logic [1:0] r_km;
    logic signed [KERN_W-1:0] r_kern [MAX_DIMS][MAX_ORDER+1];
    logic [MAX_DIMS-1:0][1:0] r_off;
    logic [MAX_DIMS-1:0][1:0] n_off;

    logic                     r_v1, r_v2, r_v3, r_ov;
    t_emit                    r_e1, r_e2, r_e3;
    logic signed [KERN_W-1:0] r_k1 [MAX_DIMS];
    logic [1:0]               r_nd1, r_nd2;
    logic signed [35:0]       r_w2;
    logic signed [KERN_W-1:0] r_k2;
    logic signed [41:0]       r_w3;
    logic [MAX_DIMS-1:0][IDX_W-1:0]     r_oidx;
    logic [MAX_CHANNELS-1:0][VAL_W-1:0] r_oval;
    logic                     r_ooor, r_olast;

    logic  w_en;
    logic  w_issue;
    logic  w_last;
    logic  w_kend;
    t_emit w_e;
    logic signed [59:0] w_p1;
    logic signed [63:0] w_r1;
    logic signed [65:0] w_p2;
    logic signed [63:0] w_r2;
    logic [MAX_CHANNELS-1:0][VAL_W-1:0] w_val;

    assign w_en    = !r_ov || o_nb.ready;
    assign w_issue = (r_st == BK_EMIT) && w_en;
    assign w_kend  = (r_kd == r_pt.nd - 2'd1) && (r_km == r_pt.order[r_kd]);

    always_comb begin
        logic carry;
        w_e   = '0;
        w_last = 1'b1;
        n_off = r_off;
        carry = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < int'(r_pt.nd)) begin
                w_e.idx[d] = r_pt.base[d] + IDX_W'(r_off[d]);
                if (r_off[d] != r_pt.order[d]) begin
                    w_last = 1'b0;
                end
            end
        end
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            if (d < int'(r_pt.nd) && carry) begin
                if (r_off[d] == r_pt.order[d]) begin
                    n_off[d] = 2'd0;
                end else begin
                    n_off[d] = r_off[d] + 2'd1;
                    carry = 1'b0;
                end
            end
        end
        w_e.grad = r_pt.grad;
        w_e.nc   = r_pt.nc;
        w_e.oor  = r_pt.oor;
        w_e.last = w_last;
    end

    always_comb begin
        o_kn_req.order = r_pt.order[r_kd];
        o_kn_req.deriv = r_pt.deriv[r_kd];
        case (r_km)
            2'd0:    o_kn_req.x = {2'b01, r_pt.frac[r_kd]};
            2'd1:    o_kn_req.x = {2'b00, r_pt.frac[r_kd]};
            2'd2:    o_kn_req.x = {2'b11, r_pt.frac[r_kd]};
            default: o_kn_req.x = {2'b10, r_pt.frac[r_kd]};
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_valid) n_st = i_pt.oor ? BK_EMIT : BK_KERN;
            BK_KERN: n_st = BK_WAIT;
            BK_WAIT: if (i_kn_done) n_st = w_kend ? BK_EMIT : BK_KERN;
            BK_EMIT: if (w_issue && w_last) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_st == BK_IDLE);
        o_kn_start = (r_st == BK_KERN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: begin
                if (i_valid) begin
                    r_pt  <= i_pt;
                    r_kd  <= 2'd0;
                    r_km  <= 2'd0;
                    r_off <= '0;
                end
            end
            BK_WAIT: begin
                if (i_kn_done) begin
                    r_kern[r_kd][r_km] <= i_kn_k;
                    if (r_km == r_pt.order[r_kd]) begin
                        r_km <= 2'd0;
                        r_kd <= r_kd + 2'd1;
                    end else begin
                        r_km <= r_km + 2'd1;
                    end
                end
            end
            BK_EMIT: begin
                if (w_issue) begin
                    r_off <= n_off;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_p1 = r_k1[0] * r_k1[1];
    assign w_r1 = rnd_sh(64'(w_p1), 22);
    assign w_p2 = r_w2 * r_k2;
    assign w_r2 = rnd_sh(w_p2[63:0], 22);

    always_comb begin
        logic signed [57:0] p;
        logic signed [63:0] v;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            p = r_w3 * $signed(r_e3.grad[c]);
            v = rnd_sh(64'(p), 17);
            if (v > VMAX) begin
                v = VMAX;
            end else if (v < VMIN) begin
                v = VMIN;
            end
            w_val[c] = (!r_e3.oor && c < int'(r_e3.nc)) ? v[VAL_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1  <= w_e;
            r_nd1 <= r_pt.nd;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_k1[d] <= r_kern[d][r_off[d]];
            end
            r_e2  <= r_e1;
            r_nd2 <= r_nd1;
            r_k2  <= r_k1[2];
            r_w2  <= (r_nd1 >= 2'd2) ? w_r1[35:0] : 36'(r_k1[0]);
            r_e3  <= r_e2;
            r_w3  <= (r_nd2 >= 2'd3) ? w_r2[41:0] : 42'(r_w2);
            r_oidx  <= r_e3.idx;
            r_oval  <= w_val;
            r_ooor  <= r_e3.oor;
            r_olast <= r_e3.last;
        end
    end

    assign o_nb.valid        = r_ov;
    assign o_nb.index_0      = r_oidx[0];
    assign o_nb.index_1      = r_oidx[1];
    assign o_nb.index_2      = r_oidx[2];
    assign o_nb.value_0      = r_oval[0];
    assign o_nb.value_1      = r_oval[1];
    assign o_nb.value_2      = r_oval[2];
    assign o_nb.value_3      = r_oval[3];
    assign o_nb.out_of_range = r_ooor;
    assign o_nb.last         = r_olast;

endmodule

[sv/spline_grid_gradient_scatter.sv]
// Top level: register port, front end, point queue, kernel unit and back end.
// A point is accepted while earlier points are still being worked on; a two-word queue
// separates the front end from the back end. Per point the back end first evaluates
// order+1 kernels per dimension on one iterative kernel unit, each run taking one
// exp(-1) step per unit of floor(e) (floor(e) up to 11), then walks the neighbor box at
// one word per cycle, unless the output stalls, through a four-stage weight pipeline.
// An out-of-range point skips the kernel pass. The user must write registers over the
// APB port only while idle; the block itself does not enforce this.
module spline_grid_gradient_scatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgs_in_if.sink      i_pt,
    sgs_out_if.source   o_nb,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sgs_pkg::*;

    t_cfg    r_cfg;
    t_point  w_fpt, w_qpt;
    logic    w_fv, w_fr, w_qv, w_qr;
    logic    w_kst, w_kdone;
    t_kn_req w_kreq;
    logic signed [KERN_W-1:0] w_k;
    logic    w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nd    <= 2'd1;
            r_cfg.nc    <= 3'd1;
            r_cfg.setup <= {MAX_DIMS{SETUP_RESET}};
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_NUM_DIMS:     r_cfg.nd       <= pwdata[1:0];
                REG_NUM_CHANNELS: r_cfg.nc       <= pwdata[2:0];
                REG_DIM0_SETUP:   r_cfg.setup[0] <= pwdata[SETUP_W-1:0];
                REG_DIM1_SETUP:   r_cfg.setup[1] <= pwdata[SETUP_W-1:0];
                REG_DIM2_SETUP:   r_cfg.setup[2] <= pwdata[SETUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_NUM_DIMS:     prdata = 32'(r_cfg.nd);
            REG_NUM_CHANNELS: prdata = 32'(r_cfg.nc);
            REG_DIM0_SETUP:   prdata = 32'(r_cfg.setup[0]);
            REG_DIM1_SETUP:   prdata = 32'(r_cfg.setup[1]);
            REG_DIM2_SETUP:   prdata = 32'(r_cfg.setup[2]);
            default:          prdata = '0;
        endcase
    end

    sgs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_cfg   (r_cfg),
        .o_pt    (w_fpt),
        .o_valid (w_fv),
        .i_ready (w_fr)
    );

    sgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (w_fpt),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .o_pt    (w_qpt),
        .o_valid (w_qv),
        .i_ready (w_qr)
    );

    sgs_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_kst),
        .i_req   (w_kreq),
        .o_done  (w_kdone),
        .o_k     (w_k)
    );

    sgs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (w_qpt),
        .i_valid    (w_qv),
        .o_ready    (w_qr),
        .o_kn_start (w_kst),
        .o_kn_req   (w_kreq),
        .i_kn_done  (w_kdone),
        .i_kn_k     (w_k),
        .o_nb       (o_nb)
    );

endmodule

[sv/sgs_chk.sv]
// Port-level assertion checker for the spline grid gradient scatter, with its bind.
module sgs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    sgs_in_if.sink     i_pt,
    sgs_out_if.source  o_nb
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nb.valid && !o_nb.ready |=> o_nb.valid)
        else $error("output word dropped while stalled");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nb.valid && o_nb.out_of_range |->
            o_nb.value_0 == 0 && o_nb.value_1 == 0 && o_nb.value_2 == 0 &&
            o_nb.value_3 == 0)
        else $error("out-of-range word carries a nonzero value");

    a_oor_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_nb.valid && o_nb.ready && !o_nb.last) && o_nb.valid |->
            o_nb.out_of_range == $past(o_nb.out_of_range))
        else $error("range flag changed inside one point");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_nb.valid)
        else $error("output valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_pt.ready)
        else $error("input not ready right after reset");

endmodule

bind spline_grid_gradient_scatter sgs_chk u_sgs_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pt    (i_pt),
    .o_nb    (o_nb)
);
